/* hw/rtl/agd_pkg.sv */
`default_nettype none
package agd_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int VERT_W       = 4;
   localparam int MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;
   localparam int MAT_AW       = $clog2(MAT_DEPTH);
   localparam int WEIGHT_W     = 16;
   localparam int DEG_W        = 6;
   localparam int EDGES_W      = 9;
   localparam int CNT_W        = 5;
   localparam int SP_W         = $clog2(MAX_VERTICES) + 1;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;

   localparam logic CSR_IDX_VERTEX_COUNT = 1'b0;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_SEARCH = 2'd3
   } mode_type;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_NOCHG   = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic                mat_we;
      logic [MAT_AW-1:0]   mat_addr;
      logic [WEIGHT_W-1:0] mat_wdata;
      logic                deg_we;
      logic [VERT_W-1:0]   deg_addr;
      logic [DEG_W-1:0]    deg_wdata;
   } mem_req_type;

endpackage
`default_nettype wire

/* hw/rtl/agd_csr.sv */
`default_nettype none
module agd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [agd_pkg::CSR_AW-1:0]   paddr,
   input  logic [agd_pkg::CSR_DW-1:0]   pwdata,
   output logic [agd_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready,
   output logic [agd_pkg::CNT_W-1:0]    live_cnt
);

   logic [agd_pkg::CNT_W-1:0] vcount_ff;
   logic [agd_pkg::CNT_W-1:0] vcount_in;
   logic                      sel_vcount;

   // register index is the word address
   assign sel_vcount = (paddr[agd_pkg::CSR_AW-1] == agd_pkg::CSR_IDX_VERTEX_COUNT);

   always_comb begin
      vcount_in = vcount_ff;
      if (psel && penable && pwrite && sel_vcount) begin
         vcount_in = pwdata[agd_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= agd_pkg::CNT_W'(agd_pkg::MAX_VERTICES);
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   assign prdata = sel_vcount ? agd_pkg::CSR_DW'(vcount_ff) : '0;
   assign pready = 1'b1;

   // cap at the matrix size
   assign live_cnt = (vcount_ff > agd_pkg::CNT_W'(agd_pkg::MAX_VERTICES)) ?
                     agd_pkg::CNT_W'(agd_pkg::MAX_VERTICES) : vcount_ff;

endmodule
`default_nettype wire

/* hw/rtl/agd_store.sv */
`default_nettype none
module agd_store (
   input  logic                          clock,
   input  agd_pkg::mem_req_type          mem_req,
   output logic [agd_pkg::WEIGHT_W-1:0]  mat_rdata,
   output logic [agd_pkg::DEG_W-1:0]     deg_rdata
);

   logic [agd_pkg::WEIGHT_W-1:0] mat_mem [agd_pkg::MAT_DEPTH];
   logic [agd_pkg::DEG_W-1:0]    deg_mem [agd_pkg::MAX_VERTICES];
   logic [agd_pkg::WEIGHT_W-1:0] mat_rdata_ff;
   logic [agd_pkg::DEG_W-1:0]    deg_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.mat_we) begin
         mat_mem[mem_req.mat_addr] <= mem_req.mat_wdata;
      end
      mat_rdata_ff <= mat_mem[mem_req.mat_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_req.deg_we) begin
         deg_mem[mem_req.deg_addr] <= mem_req.deg_wdata;
      end
      deg_rdata_ff <= deg_mem[mem_req.deg_addr];
   end

   assign mat_rdata = mat_rdata_ff;
   assign deg_rdata = deg_rdata_ff;

endmodule
`default_nettype wire

/* hw/rtl/agd_ctrl.sv */
`default_nettype none
module agd_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [agd_pkg::CNT_W-1:0]     live_cnt,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [agd_pkg::VERT_W-1:0]    req_src_vertex,
   input  logic [agd_pkg::VERT_W-1:0]    req_dst_vertex,
   input  logic [agd_pkg::WEIGHT_W-1:0]  req_edge_weight,
   output agd_pkg::mem_req_type          mem_req,
   input  logic [agd_pkg::WEIGHT_W-1:0]  mat_rdata,
   input  logic [agd_pkg::DEG_W-1:0]     deg_rdata,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [agd_pkg::WEIGHT_W-1:0]  rsp_weight_out,
   output logic [agd_pkg::DEG_W-1:0]     rsp_degree_out,
   output logic [agd_pkg::EDGES_W-1:0]   rsp_edge_total,
   output logic [agd_pkg::VERT_W-1:0]    rsp_visit_vertex,
   output logic [agd_pkg::VERT_W-1:0]    rsp_parent_vertex,
   output logic                          rsp_is_root,
   output logic                          rsp_last
);

   localparam int VW = agd_pkg::VERT_W;
   localparam int NV = agd_pkg::MAX_VERTICES;

   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_FETCH   = 9'b000000100,
      ST_UPD     = 9'b000001000,
      ST_UPD_DST = 9'b000010000,
      ST_DFS_INI = 9'b000100000,
      ST_SCAN    = 9'b001000000,
      ST_POP     = 9'b010000000,
      ST_SPARE   = 9'b100000000
   } state_type;

   state_type                    state_ff, state_in;
   agd_pkg::mode_type            mode_ff, mode_in;
   logic [VW-1:0]                src_ff, src_in;
   logic [VW-1:0]                dst_ff, dst_in;
   logic [agd_pkg::WEIGHT_W-1:0] wgt_ff, wgt_in;
   logic [agd_pkg::WEIGHT_W-1:0] cur_w_ff, cur_w_in;
   logic [agd_pkg::DEG_W-1:0]    deg_s_ff, deg_s_in;
   logic [agd_pkg::DEG_W-1:0]    deg_d_ff, deg_d_in;
   logic [agd_pkg::EDGES_W-1:0]  edges_ff, edges_in;
   logic [agd_pkg::MAT_AW-1:0]   clr_ff, clr_in;
   logic [NV-1:0]                visited_ff, visited_in;
   logic [VW-1:0]                cur_v_ff, cur_v_in;
   logic [agd_pkg::CNT_W-1:0]    scan_ff, scan_in;
   logic [agd_pkg::SP_W-1:0]     sp_ff, sp_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [VW-1:0]                rd_j_ff, rd_j_in;
   logic [VW-1:0]                pend_vis_ff, pend_vis_in;
   logic [VW-1:0]                pend_par_ff, pend_par_in;
   logic                         pend_root_ff, pend_root_in;

   logic                         out_vld_ff, out_vld_in;
   logic [1:0]                   out_status_ff, out_status_in;
   logic [agd_pkg::WEIGHT_W-1:0] out_weight_ff, out_weight_in;
   logic [agd_pkg::DEG_W-1:0]    out_degree_ff, out_degree_in;
   logic [agd_pkg::EDGES_W-1:0]  out_total_ff, out_total_in;
   logic [VW-1:0]                out_visit_ff, out_visit_in;
   logic [VW-1:0]                out_parent_ff, out_parent_in;
   logic                         out_root_ff, out_root_in;
   logic                         out_last_ff, out_last_in;

   // search stack: each frame holds a vertex and the column it last took
   logic [2*VW-1:0]              stack_mem [NV];
   logic [2*VW-1:0]              stack_rd_ff;
   logic                         stack_we;
   logic [2*VW-1:0]              stack_wdata;
   logic [VW-1:0]                stack_raddr;

   logic                         req_sv, src_ok, dst_ok, bad_op, present, change, self_loop;
   logic                         hit;
   logic [agd_pkg::DEG_W-1:0]    step, new_s;
   logic [1:0]                   op_status;

   assign stack_raddr = VW'(sp_ff - agd_pkg::SP_W'(1));

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[sp_ff[VW-1:0]] <= stack_wdata;
      end
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   assign req_sv    = agd_pkg::CNT_W'(req_src_vertex) < live_cnt;
   assign src_ok    = agd_pkg::CNT_W'(src_ff) < live_cnt;
   assign dst_ok    = agd_pkg::CNT_W'(dst_ff) < live_cnt;
   assign bad_op    = !src_ok || !dst_ok ||
                      (mode_ff == agd_pkg::MODE_INSERT && wgt_ff == '0);
   assign present   = (cur_w_ff != '0);
   assign change    = !bad_op &&
                      ((mode_ff == agd_pkg::MODE_INSERT && !present) ||
                       (mode_ff == agd_pkg::MODE_REMOVE && present));
   assign self_loop = (src_ff == dst_ff);
   assign step      = self_loop ? agd_pkg::DEG_W'(2) : agd_pkg::DEG_W'(1);
   assign new_s     = !change ? deg_s_ff :
                      (mode_ff == agd_pkg::MODE_INSERT) ? deg_s_ff + step : deg_s_ff - step;
   assign hit       = rd_vld_ff && (mat_rdata != '0) && !visited_ff[rd_j_ff];

   always_comb begin
      case (mode_ff)
         agd_pkg::MODE_INSERT: op_status = present ? agd_pkg::STATUS_NOCHG
                                                   : agd_pkg::STATUS_DONE;
         default:              op_status = present ? agd_pkg::STATUS_DONE
                                                   : agd_pkg::STATUS_NOCHG;
      endcase
      if (bad_op) begin
         op_status = agd_pkg::STATUS_INVALID;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      wgt_in       = wgt_ff;
      cur_w_in     = cur_w_ff;
      deg_s_in     = deg_s_ff;
      deg_d_in     = deg_d_ff;
      edges_in     = edges_ff;
      clr_in       = clr_ff;
      visited_in   = visited_ff;
      cur_v_in     = cur_v_ff;
      scan_in      = scan_ff;
      sp_in        = sp_ff;
      rd_vld_in    = 1'b0;
      rd_j_in      = rd_j_ff;
      pend_vis_in  = pend_vis_ff;
      pend_par_in  = pend_par_ff;
      pend_root_in = pend_root_ff;
      stack_we     = 1'b0;
      stack_wdata  = {cur_v_ff, rd_j_ff};

      out_vld_in    = 1'b0;
      out_status_in = agd_pkg::STATUS_DONE;
      out_weight_in = '0;
      out_degree_in = deg_s_ff;
      out_total_in  = edges_ff;
      out_visit_in  = '0;
      out_parent_in = '0;
      out_root_in   = 1'b0;
      out_last_in   = 1'b0;

      mem_req.mat_we    = 1'b0;
      mem_req.mat_addr  = {cur_v_ff, scan_ff[VW-1:0]};
      mem_req.mat_wdata = '0;
      mem_req.deg_we    = 1'b0;
      mem_req.deg_addr  = src_ff;
      mem_req.deg_wdata = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep both stores to zero after reset
            mem_req.mat_we   = 1'b1;
            mem_req.mat_addr = clr_ff;
            mem_req.deg_we   = 1'b1;
            mem_req.deg_addr = clr_ff[VW-1:0];
            clr_in           = clr_ff + agd_pkg::MAT_AW'(1);
            if (clr_ff == agd_pkg::MAT_AW'(agd_pkg::MAT_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            mem_req.mat_addr = {req_src_vertex, req_dst_vertex};
            mem_req.deg_addr = req_src_vertex;
            if (start) begin
               mode_in = agd_pkg::mode_type'(req_mode);
               src_in  = req_src_vertex;
               dst_in  = req_dst_vertex;
               wgt_in  = req_edge_weight;
               if (agd_pkg::mode_type'(req_mode) == agd_pkg::MODE_SEARCH) begin
                  if (!req_sv) begin
                     out_vld_in    = 1'b1;
                     out_status_in = agd_pkg::STATUS_INVALID;
                     out_degree_in = '0;
                     out_last_in   = 1'b1;
                  end else begin
                     visited_in                 = '0;
                     visited_in[req_src_vertex] = 1'b1;
                     pend_vis_in  = req_src_vertex;
                     pend_par_in  = req_src_vertex;
                     pend_root_in = 1'b1;
                     cur_v_in     = req_src_vertex;
                     scan_in      = '0;
                     sp_in        = '0;
                     state_in     = ST_DFS_INI;
                  end
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cur_w_in         = mat_rdata;
            deg_s_in         = deg_rdata;
            mem_req.deg_addr = dst_ff;
            state_in         = ST_UPD;
         end
         ST_UPD: begin
            deg_d_in = deg_rdata;
            if (change) begin
               mem_req.mat_we    = 1'b1;
               mem_req.mat_addr  = {src_ff, dst_ff};
               mem_req.mat_wdata = (mode_ff == agd_pkg::MODE_INSERT) ? wgt_ff : '0;
               mem_req.deg_we    = 1'b1;
               mem_req.deg_addr  = src_ff;
               mem_req.deg_wdata = new_s;
               edges_in = (mode_ff == agd_pkg::MODE_INSERT) ?
                          edges_ff + agd_pkg::EDGES_W'(1) :
                          edges_ff - agd_pkg::EDGES_W'(1);
            end
            out_vld_in    = 1'b1;
            out_status_in = op_status;
            out_weight_in = (!bad_op && mode_ff == agd_pkg::MODE_QUERY) ? cur_w_ff : '0;
            out_degree_in = (bad_op && !src_ok) ? '0 : new_s;
            out_total_in  = edges_in;
            out_last_in   = 1'b1;
            state_in      = (change && !self_loop) ? ST_UPD_DST : ST_IDLE;
         end
         ST_UPD_DST: begin
            mem_req.deg_we    = 1'b1;
            mem_req.deg_addr  = dst_ff;
            mem_req.deg_wdata = (mode_ff == agd_pkg::MODE_INSERT) ?
                                deg_d_ff + agd_pkg::DEG_W'(1) :
                                deg_d_ff - agd_pkg::DEG_W'(1);
            state_in = ST_IDLE;
         end
         ST_DFS_INI: begin
            deg_s_in = deg_rdata;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit) begin
               // descend: the read in flight belongs to the old row, drop it
               visited_in[rd_j_ff] = 1'b1;
               out_vld_in    = 1'b1;
               out_visit_in  = pend_vis_ff;
               out_parent_in = pend_par_ff;
               out_root_in   = pend_root_ff;
               pend_vis_in   = rd_j_ff;
               pend_par_in   = cur_v_ff;
               pend_root_in  = 1'b0;
               // at most one frame per vertex, so the stack cannot fill
               stack_we      = 1'b1;
               sp_in         = sp_ff + agd_pkg::SP_W'(1);
               cur_v_in      = rd_j_ff;
               scan_in       = '0;
            end else if (scan_ff < live_cnt) begin
               rd_vld_in = 1'b1;
               rd_j_in   = scan_ff[VW-1:0];
               scan_in   = scan_ff + agd_pkg::CNT_W'(1);
            end else if (sp_ff == '0) begin
               out_vld_in    = 1'b1;
               out_visit_in  = pend_vis_ff;
               out_parent_in = pend_par_ff;
               out_root_in   = pend_root_ff;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               sp_in    = sp_ff - agd_pkg::SP_W'(1);
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            cur_v_in = stack_rd_ff[2*VW-1:VW];
            scan_in  = agd_pkg::CNT_W'(stack_rd_ff[VW-1:0]) + agd_pkg::CNT_W'(1);
            state_in = ST_SCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         edges_ff   <= '0;
         visited_ff <= '0;
         sp_ff      <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         edges_ff   <= edges_in;
         visited_ff <= visited_in;
         sp_ff      <= sp_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      wgt_ff        <= wgt_in;
      cur_w_ff      <= cur_w_in;
      deg_s_ff      <= deg_s_in;
      deg_d_ff      <= deg_d_in;
      cur_v_ff      <= cur_v_in;
      scan_ff       <= scan_in;
      rd_j_ff       <= rd_j_in;
      pend_vis_ff   <= pend_vis_in;
      pend_par_ff   <= pend_par_in;
      pend_root_ff  <= pend_root_in;
      out_status_ff <= out_status_in;
      out_weight_ff <= out_weight_in;
      out_degree_ff <= out_degree_in;
      out_total_ff  <= out_total_in;
      out_visit_ff  <= out_visit_in;
      out_parent_ff <= out_parent_in;
      out_root_ff   <= out_root_in;
      out_last_ff   <= out_last_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = out_vld_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_weight_out    = out_weight_ff;
   assign rsp_degree_out    = out_degree_ff;
   assign rsp_edge_total    = out_total_ff;
   assign rsp_visit_vertex  = out_visit_ff;
   assign rsp_parent_vertex = out_parent_ff;
   assign rsp_is_root       = out_root_ff;
   assign rsp_last          = out_last_ff;

endmodule
`default_nettype wire

/* hw/rtl/adjacency_matrix_graph_dfs.sv */
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+-------------------------------------------
// request   | start in, busy out            | req_mode, req_src_vertex, req_dst_vertex,
//           |                               | req_edge_weight
// response  | rsp_valid out, one cycle each | rsp_status .. rsp_last
// registers | psel/penable/pwrite, pready   | paddr, pwdata, prdata (vertex_count at 0)
//
// After reset the block sweeps the weight matrix and degree table with busy high.
// Insert, remove and query keep busy high through a read state, an update state and, when an
// edge changes between distinct vertices, a second degree write; the result is registered from
// the update state. An invalid search start answers in the next cycle and leaves busy low.
// A search reads one matrix entry per cycle while it scans a row, but not while it descends,
// ends a row or returns to the parent: up to n*n reads; no receiver stalls.
`default_nettype none
module adjacency_matrix_graph_dfs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [agd_pkg::VERT_W-1:0]    req_src_vertex,
   input  logic [agd_pkg::VERT_W-1:0]    req_dst_vertex,
   input  logic [agd_pkg::WEIGHT_W-1:0]  req_edge_weight,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [agd_pkg::WEIGHT_W-1:0]  rsp_weight_out,
   output logic [agd_pkg::DEG_W-1:0]     rsp_degree_out,
   output logic [agd_pkg::EDGES_W-1:0]   rsp_edge_total,
   output logic [agd_pkg::VERT_W-1:0]    rsp_visit_vertex,
   output logic [agd_pkg::VERT_W-1:0]    rsp_parent_vertex,
   output logic                          rsp_is_root,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [agd_pkg::CSR_AW-1:0]    paddr,
   input  logic [agd_pkg::CSR_DW-1:0]    pwdata,
   output logic [agd_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   logic [agd_pkg::CNT_W-1:0]    live_cnt;
   agd_pkg::mem_req_type         mem_req;
   logic [agd_pkg::WEIGHT_W-1:0] mat_rdata;
   logic [agd_pkg::DEG_W-1:0]    deg_rdata;

   agd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .live_cnt (live_cnt)
   );

   agd_store u_store (
      .clock     (clock),
      .mem_req   (mem_req),
      .mat_rdata (mat_rdata),
      .deg_rdata (deg_rdata)
   );

   agd_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .live_cnt          (live_cnt),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_src_vertex    (req_src_vertex),
      .req_dst_vertex    (req_dst_vertex),
      .req_edge_weight   (req_edge_weight),
      .mem_req           (mem_req),
      .mat_rdata         (mat_rdata),
      .deg_rdata         (deg_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_weight_out    (rsp_weight_out),
      .rsp_degree_out    (rsp_degree_out),
      .rsp_edge_total    (rsp_edge_total),
      .rsp_visit_vertex  (rsp_visit_vertex),
      .rsp_parent_vertex (rsp_parent_vertex),
      .rsp_is_root       (rsp_is_root),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire

/* hw/rtl/agd_chk.sv */
`default_nettype none
module agd_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [1:0]                    req_mode,
   input logic                          rsp_valid,
   input logic [1:0]                    rsp_status,
   input logic [agd_pkg::WEIGHT_W-1:0]  rsp_weight_out,
   input logic [agd_pkg::VERT_W-1:0]    rsp_visit_vertex,
   input logic [agd_pkg::VERT_W-1:0]    rsp_parent_vertex,
   input logic                          rsp_is_root,
   input logic                          rsp_last
);

   // edge operations always go through the memory read-modify-write
   a_edge_op_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode != agd_pkg::MODE_SEARCH) |=> busy)
      else $error("edge operation did not hold busy");

   a_invalid_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == agd_pkg::STATUS_INVALID) |-> rsp_last)
      else $error("invalid item gave more than one result");

   a_root_self: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_root |-> (rsp_visit_vertex == rsp_parent_vertex))
      else $error("search root not its own parent");

   // a search result that is not the last means the search still runs
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("search ended without a last result");

   a_weight_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_weight_out != '0) |-> (rsp_status == agd_pkg::STATUS_DONE))
      else $error("weight reported for absent edge");

endmodule

bind adjacency_matrix_graph_dfs agd_chk u_agd_chk (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_mode          (req_mode),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_weight_out    (rsp_weight_out),
   .rsp_visit_vertex  (rsp_visit_vertex),
   .rsp_parent_vertex (rsp_parent_vertex),
   .rsp_is_root       (rsp_is_root),
   .rsp_last          (rsp_last)
);
`default_nettype wire

/* tb/sv/adjacency_matrix_graph_dfs_test.sv */
`timescale 1ns / 100ps
module adjacency_matrix_graph_dfs_test;

   localparam int CYCLE_LIMIT = 500_000;
   localparam int PHASE_ITEMS = 20;
   localparam logic [agd_pkg::CSR_AW-1:0] VCOUNT_ADDR =
      {agd_pkg::CSR_IDX_VERTEX_COUNT, 2'b00};
   localparam logic [agd_pkg::CSR_AW-1:0] SPARE_ADDR  =
      {~agd_pkg::CSR_IDX_VERTEX_COUNT, 2'b00};

   typedef struct packed {
      logic [1:0]                   status;
      logic [agd_pkg::WEIGHT_W-1:0] weight;
      logic [agd_pkg::DEG_W-1:0]    degree;
      logic [agd_pkg::EDGES_W-1:0]  edges;
      logic [agd_pkg::VERT_W-1:0]   visit;
      logic [agd_pkg::VERT_W-1:0]   parent;
      logic                         root;
      logic                         last;
   } graph_reply_type;

   typedef struct {
      bit                           is_csr;
      logic [agd_pkg::CSR_AW-1:0]   addr;
      logic [agd_pkg::CSR_DW-1:0]   value;
      agd_pkg::mode_type            mode;
      logic [agd_pkg::VERT_W-1:0]   src;
      logic [agd_pkg::VERT_W-1:0]   dst;
      logic [agd_pkg::WEIGHT_W-1:0] weight;
      bit                           typed;
      graph_reply_type              reply;
   } drill_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_mode = agd_pkg::MODE_INSERT;
   logic [agd_pkg::VERT_W-1:0]   req_src_vertex = '0;
   logic [agd_pkg::VERT_W-1:0]   req_dst_vertex = '0;
   logic [agd_pkg::WEIGHT_W-1:0] req_edge_weight = '0;
   logic                         rsp_valid;
   logic [1:0]                   rsp_status;
   logic [agd_pkg::WEIGHT_W-1:0] rsp_weight_out;
   logic [agd_pkg::DEG_W-1:0]    rsp_degree_out;
   logic [agd_pkg::EDGES_W-1:0]  rsp_edge_total;
   logic [agd_pkg::VERT_W-1:0]   rsp_visit_vertex;
   logic [agd_pkg::VERT_W-1:0]   rsp_parent_vertex;
   logic                         rsp_is_root;
   logic                         rsp_last;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [agd_pkg::CSR_AW-1:0]   paddr = '0;
   logic [agd_pkg::CSR_DW-1:0]   pwdata = '0;
   logic [agd_pkg::CSR_DW-1:0]   prdata;
   logic                         pready;

   // shadow of the graph store
   logic [agd_pkg::WEIGHT_W-1:0] edge_weight [agd_pkg::MAX_VERTICES][agd_pkg::MAX_VERTICES];
   logic [agd_pkg::DEG_W-1:0]    vertex_degree [agd_pkg::MAX_VERTICES];
   logic [agd_pkg::EDGES_W-1:0]  edge_total = '0;
   logic [agd_pkg::CNT_W-1:0]    vertex_limit = 5'd16;

   graph_reply_type due_replies[$];
   drill_row_type   drill[$];

   int  mismatches = 0;
   int  items_sent = 0;
   int  searches_run = 0;
   int  replies_seen = 0;
   int  settings_tried = 0;
   int  cycles = 0;
   bit  no_gaps = 1'b0;

   adjacency_matrix_graph_dfs u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_src_vertex(req_src_vertex),
      .req_dst_vertex(req_dst_vertex), .req_edge_weight(req_edge_weight),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_weight_out(rsp_weight_out),
      .rsp_degree_out(rsp_degree_out), .rsp_edge_total(rsp_edge_total),
      .rsp_visit_vertex(rsp_visit_vertex), .rsp_parent_vertex(rsp_parent_vertex),
      .rsp_is_root(rsp_is_root), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies still due", cycles,
                  due_replies.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want)
         report_mismatch($sformatf("reply %0d %s got %0d want %0d", replies_seen, name,
                                   got, want));
   endtask

   function automatic int unsigned live_vertices();
      return (vertex_limit > agd_pkg::MAX_VERTICES) ? agd_pkg::MAX_VERTICES : vertex_limit;
   endfunction

   // Apply one operation to the shadow store and queue the replies it causes.
   task automatic apply_graph_op(input agd_pkg::mode_type m,
                                 input logic [agd_pkg::VERT_W-1:0] s,
                                 input logic [agd_pkg::VERT_W-1:0] d,
                                 input logic [agd_pkg::WEIGHT_W-1:0] w);
      int unsigned                n;
      bit                         src_ok;
      bit                         dst_ok;
      graph_reply_type            r;
      graph_reply_type            walk[$];
      logic [agd_pkg::VERT_W-1:0] stack_v [agd_pkg::MAX_VERTICES];
      int                         resume_at [agd_pkg::MAX_VERTICES];
      bit                         marked [agd_pkg::MAX_VERTICES];
      int                         depth;
      int                         top;
      int                         j;
      logic [agd_pkg::VERT_W-1:0] v;
      bit                         pushed;
      n = live_vertices();
      src_ok = s < n;
      dst_ok = d < n;
      r = '0;
      r.edges = edge_total;
      r.last = 1'b1;
      if (m == agd_pkg::MODE_SEARCH) begin
         if (!src_ok) begin
            r.status = agd_pkg::STATUS_INVALID;
            due_replies.push_back(r);
            return;
         end
         foreach (marked[k]) marked[k] = 1'b0;
         marked[s] = 1'b1;
         r.status = agd_pkg::STATUS_DONE;
         r.degree = vertex_degree[s];
         r.visit = s;
         r.parent = s;
         r.root = 1'b1;
         r.last = 1'b0;
         walk.push_back(r);
         r.root = 1'b0;
         stack_v[0] = s;
         resume_at[0] = 0;
         depth = 1;
         while (depth > 0) begin
            top = depth - 1;
            v = stack_v[top];
            pushed = 1'b0;
            // resume the scan of this row where the last descent left it
            while (!pushed && resume_at[top] < n) begin
               j = resume_at[top];
               resume_at[top]++;
               if (edge_weight[v][j] != 0 && !marked[j]) begin
                  marked[j] = 1'b1;
                  r.visit = agd_pkg::VERT_W'(j);
                  r.parent = v;
                  walk.push_back(r);
                  if (depth < agd_pkg::MAX_VERTICES) begin
                     stack_v[depth] = agd_pkg::VERT_W'(j);
                     resume_at[depth] = 0;
                     depth++;
                  end
                  pushed = 1'b1;
               end
            end
            if (!pushed) depth--;
         end
         walk[walk.size()-1].last = 1'b1;
         foreach (walk[k]) due_replies.push_back(walk[k]);
         return;
      end
      if (!src_ok || !dst_ok || (m == agd_pkg::MODE_INSERT && w == 0)) begin
         r.status = agd_pkg::STATUS_INVALID;
         r.degree = src_ok ? vertex_degree[s] : '0;
         due_replies.push_back(r);
         return;
      end
      r.status = agd_pkg::STATUS_DONE;
      case (m)
         agd_pkg::MODE_INSERT: begin
            if (edge_weight[s][d] != 0) begin
               r.status = agd_pkg::STATUS_NOCHG;
            end else begin
               edge_weight[s][d] = w;
               edge_total++;
               vertex_degree[s]++;
               vertex_degree[d]++;
            end
         end
         agd_pkg::MODE_REMOVE: begin
            if (edge_weight[s][d] == 0) begin
               r.status = agd_pkg::STATUS_NOCHG;
            end else begin
               edge_weight[s][d] = '0;
               edge_total--;
               vertex_degree[s]--;
               vertex_degree[d]--;
            end
         end
         default: begin
            if (edge_weight[s][d] == 0) r.status = agd_pkg::STATUS_NOCHG;
            else r.weight = edge_weight[s][d];
         end
      endcase
      r.degree = vertex_degree[s];
      r.edges = edge_total;
      due_replies.push_back(r);
   endtask

   always @(negedge clock) begin
      graph_reply_type seen;
      graph_reply_type want;
      if (!reset && rsp_valid) begin
         seen = '{rsp_status, rsp_weight_out, rsp_degree_out, rsp_edge_total,
                  rsp_visit_vertex, rsp_parent_vertex, rsp_is_root, rsp_last};
         replies_seen++;
         if (due_replies.size() == 0) begin
            report_mismatch($sformatf("reply %0d arrived with none due (visit %0d)",
                                      replies_seen, seen.visit));
         end else begin
            want = due_replies.pop_front();
            check_field("status", seen.status, want.status);
            check_field("weight_out", seen.weight, want.weight);
            check_field("degree_out", seen.degree, want.degree);
            check_field("edge_total", seen.edges, want.edges);
            check_field("visit_vertex", seen.visit, want.visit);
            check_field("parent_vertex", seen.parent, want.parent);
            check_field("is_root", seen.root, want.root);
            check_field("last", seen.last, want.last);
         end
      end
   end

   task automatic send_item(input agd_pkg::mode_type m, input logic [agd_pkg::VERT_W-1:0] s,
                            input logic [agd_pkg::VERT_W-1:0] d,
                            input logic [agd_pkg::WEIGHT_W-1:0] w,
                            input bit typed, input graph_reply_type typed_reply);
      if (!no_gaps && $urandom_range(0, 99) < 8) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= m;
      req_src_vertex <= s;
      req_dst_vertex <= d;
      req_edge_weight <= w;
      // busy low here means the item is taken at the next rising edge
      do @(negedge clock); while (busy);
      apply_graph_op(m, s, d, w);
      if (typed) begin
         void'(due_replies.pop_back());
         due_replies.push_back(typed_reply);
      end
      items_sent++;
      if (m == agd_pkg::MODE_SEARCH) searches_run++;
      @(posedge clock);
   endtask

   // drop start and wait until every reply is in and the block is idle
   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (due_replies.size() != 0 || busy);
      @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [agd_pkg::CSR_AW-1:0] addr,
                             input logic [agd_pkg::CSR_DW-1:0] wdata,
                             output logic [agd_pkg::CSR_DW-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      rdata = prdata;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [agd_pkg::CSR_AW-1:0] addr,
                                     input logic [agd_pkg::CSR_DW-1:0] value);
      logic [agd_pkg::CSR_DW-1:0] rd;
      csr_access(1'b1, addr, value, rd);
      if (addr[2] == agd_pkg::CSR_IDX_VERTEX_COUNT) vertex_limit = value[agd_pkg::CNT_W-1:0];
      settings_tried++;
      csr_access(1'b0, VCOUNT_ADDR, '0, rd);
      if (rd !== agd_pkg::CSR_DW'(vertex_limit))
         report_mismatch($sformatf("vertex_count reads %0h want %0h", rd, vertex_limit));
   endtask

   function automatic graph_reply_type edge_reply(input logic [1:0] st,
                                                  input logic [agd_pkg::WEIGHT_W-1:0] w,
                                                  input logic [agd_pkg::DEG_W-1:0] deg,
                                                  input logic [agd_pkg::EDGES_W-1:0] tot);
      graph_reply_type r;
      r = '0;
      r.status = st;
      r.weight = w;
      r.degree = deg;
      r.edges = tot;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void add_op(input agd_pkg::mode_type m,
                                  input logic [agd_pkg::VERT_W-1:0] s,
                                  input logic [agd_pkg::VERT_W-1:0] d,
                                  input logic [agd_pkg::WEIGHT_W-1:0] w,
                                  input bit typed = 1'b0,
                                  input graph_reply_type reply = '0);
      drill_row_type row;
      row.is_csr = 1'b0;
      row.addr = '0;
      row.value = '0;
      row.mode = m;
      row.src = s;
      row.dst = d;
      row.weight = w;
      row.typed = typed;
      row.reply = reply;
      drill.push_back(row);
   endfunction

   function automatic void add_csr(input logic [agd_pkg::CSR_AW-1:0] addr,
                                   input logic [agd_pkg::CSR_DW-1:0] value);
      drill_row_type row;
      row.is_csr = 1'b1;
      row.addr = addr;
      row.value = value;
      row.mode = agd_pkg::MODE_INSERT;
      row.src = '0;
      row.dst = '0;
      row.weight = '0;
      row.typed = 1'b0;
      row.reply = '0;
      drill.push_back(row);
   endfunction

   function automatic logic [agd_pkg::VERT_W-1:0] pick_vertex(input int unsigned n);
      if (n == 0 || $urandom_range(0, 9) == 0)
         return agd_pkg::VERT_W'($urandom_range(0, 15));
      return agd_pkg::VERT_W'($urandom_range(0, n - 1));
   endfunction

   initial begin
      int unsigned                  phase_count [10];
      int unsigned                  n;
      int                           ins_pct;
      int                           pick;
      agd_pkg::mode_type            m;
      logic [agd_pkg::VERT_W-1:0]   s;
      logic [agd_pkg::VERT_W-1:0]   d;
      logic [agd_pkg::WEIGHT_W-1:0] w;
      foreach (edge_weight[i, j]) edge_weight[i][j] = '0;
      foreach (vertex_degree[i]) vertex_degree[i] = '0;
      phase_count = '{16, 16, 4, 1, 0, 31, 16, 2, $urandom_range(0, 31), 16};

      // full count after reset: extremes, self-loop, repeats and misses
      add_op(agd_pkg::MODE_QUERY, 0, 0, 0, 1, edge_reply(agd_pkg::STATUS_NOCHG, 0, 0, 0));
      add_op(agd_pkg::MODE_INSERT, 0, 15, 16'hFFFF, 1,
             edge_reply(agd_pkg::STATUS_DONE, 0, 1, 1));
      add_op(agd_pkg::MODE_INSERT, 15, 15, 16'h0001);
      add_op(agd_pkg::MODE_INSERT, 0, 15, 16'h1234, 1,
             edge_reply(agd_pkg::STATUS_NOCHG, 0, 1, 2));
      add_op(agd_pkg::MODE_INSERT, 2, 3, 16'h0000, 1,
             edge_reply(agd_pkg::STATUS_INVALID, 0, 0, 2));
      add_op(agd_pkg::MODE_QUERY, 0, 15, 0, 1,
             edge_reply(agd_pkg::STATUS_DONE, 16'hFFFF, 1, 2));
      add_op(agd_pkg::MODE_REMOVE, 1, 2, 0, 1, edge_reply(agd_pkg::STATUS_NOCHG, 0, 0, 2));
      add_op(agd_pkg::MODE_REMOVE, 15, 15, 16'hA5A5);
      add_op(agd_pkg::MODE_INSERT, 0, 1, 16'h0007);
      add_op(agd_pkg::MODE_INSERT, 1, 2, 16'h0008);
      add_op(agd_pkg::MODE_INSERT, 2, 0, 16'h0009);
      add_op(agd_pkg::MODE_INSERT, 1, 3, 16'h000A);
      add_op(agd_pkg::MODE_INSERT, 0, 4, 16'h000B);
      add_op(agd_pkg::MODE_INSERT, 4, 4, 16'h000C);
      add_op(agd_pkg::MODE_SEARCH, 0, 9, 16'h5A5A);
      add_op(agd_pkg::MODE_SEARCH, 5, 0, 0);
      // shrink: edges to vertex 15 stay counted but are out of reach
      add_csr(VCOUNT_ADDR, 4);
      add_op(agd_pkg::MODE_INSERT, 5, 0, 16'h0001);
      add_op(agd_pkg::MODE_REMOVE, 0, 15, 0);
      add_op(agd_pkg::MODE_SEARCH, 9, 0, 0);
      add_op(agd_pkg::MODE_SEARCH, 0, 0, 0);
      add_csr(SPARE_ADDR, 32'hFFFF_FFFF);
      add_csr(VCOUNT_ADDR, 0);
      add_op(agd_pkg::MODE_SEARCH, 0, 0, 0);
      add_op(agd_pkg::MODE_INSERT, 0, 0, 16'h0001);
      add_csr(VCOUNT_ADDR, 31);
      add_op(agd_pkg::MODE_SEARCH, 2, 0, 0);
      add_csr(VCOUNT_ADDR, 1);
      add_op(agd_pkg::MODE_INSERT, 0, 0, 16'h0005);
      add_op(agd_pkg::MODE_SEARCH, 0, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      settle();

      foreach (drill[i]) begin
         if (drill[i].is_csr) begin
            settle();
            write_vertex_count(drill[i].addr, drill[i].value);
         end else begin
            send_item(drill[i].mode, drill[i].src, drill[i].dst, drill[i].weight,
                      drill[i].typed, drill[i].reply);
         end
      end

      foreach (phase_count[p]) begin
         settle();
         write_vertex_count(VCOUNT_ADDR, phase_count[p]);
         n = live_vertices();
         no_gaps = (p == 6 || p == 7);
         ins_pct = (p == 0) ? 70 : $urandom_range(25, 60);
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < ins_pct) m = agd_pkg::MODE_INSERT;
            else m = agd_pkg::mode_type'($urandom_range(1, 3));
            s = pick_vertex(n);
            d = pick_vertex(n);
            // aim removes and queries at a stored edge half the time
            if ((m == agd_pkg::MODE_REMOVE || m == agd_pkg::MODE_QUERY) &&
                $urandom_range(0, 1)) begin
               for (int k = 0; k < agd_pkg::MAX_VERTICES; k++)
                  if (k < n && edge_weight[s][k] != 0) d = agd_pkg::VERT_W'(k);
            end
            case ($urandom_range(0, 19))
               0:       w = '0;
               1:       w = '1;
               2:       w = 16'd1;
               default: w = agd_pkg::WEIGHT_W'($urandom_range(0, 65535));
            endcase
            send_item(m, s, d, w, 1'b0, '0);
         end
      end

      settle();
      repeat (16) @(posedge clock);
      if (due_replies.size() != 0)
         report_mismatch($sformatf("%0d replies never arrived", due_replies.size()));
      $display("Covered %0d items (%0d searches) over %0d vertex_count writes;",
               items_sent, searches_run, settings_tried);
      $display("checked %0d replies in %0d cycles, %0d mismatches.",
               replies_seen, cycles, mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/agd_pkg.sv
hw/rtl/agd_csr.sv
hw/rtl/agd_store.sv
hw/rtl/agd_ctrl.sv
hw/rtl/adjacency_matrix_graph_dfs.sv
hw/rtl/agd_chk.sv
tb/sv/adjacency_matrix_graph_dfs_test.sv
